// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stb_pkg.sv =====
// ---------------------------------------------------------------------------
// stb_pkg
// Command codes and slot types for the software timer bank.
// ---------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  // Command codes
  localparam logic [3:0] CMD_TICK     = 4'd0;
  localparam logic [3:0] CMD_START    = 4'd1;
  localparam logic [3:0] CMD_STOP     = 4'd2;
  localparam logic [3:0] CMD_SET_EVT  = 4'd3;
  localparam logic [3:0] CMD_CLR_EVT  = 4'd4;
  localparam logic [3:0] CMD_POLL     = 4'd5;
  localparam logic [3:0] CMD_QUERY    = 4'd6;
  localparam logic [3:0] CMD_DISPATCH = 4'd7;
  localparam logic [3:0] CMD_DELAY    = 4'd8;

  // Clock value at which the millisecond clock wraps to zero
  localparam logic [32:0] CLOCK_TOP = 33'h0_FFFF_FFFF;

  // Countdown state of one slot as seen by the decrement unit
  typedef struct packed {
    logic        flag;
    logic        auto_rl;
    logic [31:0] reload;
    logic [31:0] remaining;
  } slot_state_t;

endpackage

`default_nettype wire

// ===== rtl/stb_decr.sv =====
// ---------------------------------------------------------------------------
// stb_decr
// Shared soft-tick decrement unit: one slot per use, one subtract and compare.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_decr import stb_pkg::*; #(
  parameter int unsigned SOFT_TICK_MS = 10
) (
  input  wire slot_state_t slot_i,
  output slot_state_t      slot_o
);

  localparam logic [31:0] Step = 32'(SOFT_TICK_MS);

  logic is_zero;
  logic expires;

  assign is_zero = (slot_i.remaining == 32'd0);
  assign expires = (slot_i.remaining <= Step);

  // Idle slots pass through; expiry flags and reloads or stops the slot
  always_comb begin
    slot_o = slot_i;
    if (!is_zero) begin
      if (expires) begin
        slot_o.flag      = 1'b1;
        slot_o.remaining = slot_i.auto_rl ? slot_i.reload : 32'd0;
      end else begin
        slot_o.remaining = slot_i.remaining - Step;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/software_timer_bank.sv =====
// ---------------------------------------------------------------------------
// software_timer_bank
// Bank of countdown timers driven by a command channel.
// ---------------------------------------------------------------------------
// Usage:
//   A command item (command_i, timer_mask_i, auto_reload_i, count_value_i) is
//   taken at a rising edge with start_i high and busy_o low. busy_o stays high
//   while the item is worked on. The result (accepted_o, answer_o,
//   dispatched_id_o, event_word_o, clock_ms_o, delay_busy_o) is shown for
//   one cycle with done_o high; the receiver cannot stall it.
// Sequence: the accepted item is latched, then worked in the execute state:
//   - slot commands, delay load, hard tick without soft tick: result set there
//   - hard tick that fires a soft tick: then a scan state in which the shared
//     decrement unit walks every slot, one per cycle
//   - dispatch: then a scan from slot 0 up to the lowest flagged slot, or
//     through all TIMER_COUNT slots when none is flagged
//   A new item may be started in the same cycle that done_o is high.
// Reset: all slots, events, clock, tick accumulator and delay go to zero;
//   the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module software_timer_bank import stb_pkg::*; #(
  parameter int unsigned TIMER_COUNT  = 16,
  parameter int unsigned HARD_TICK_MS = 1,
  parameter int unsigned SOFT_TICK_MS = 10,
  parameter logic [31:0] MAX_PERIOD   = 32'hFFFF_FFFF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  command_i,
  input  wire logic [15:0] timer_mask_i,
  input  wire logic        auto_reload_i,
  input  wire logic [31:0] count_value_i,
  output logic             done_o,
  output logic             accepted_o,
  output logic             answer_o,
  output logic [15:0]      dispatched_id_o,
  output logic [15:0]      event_word_o,
  output logic [31:0]      clock_ms_o,
  output logic             delay_busy_o
);

  localparam int unsigned IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  state_e state_q;

  // Latched command item
  logic [3:0]  cmd_q;
  logic [15:0] mask_q;
  logic        mode_q;
  logic [31:0] count_q;
  logic        valid_q;
  logic [IdxW-1:0] idx_q;

  // Slot storage
  logic [15:0] slot_id_q     [TIMER_COUNT];
  logic        slot_in_use_q [TIMER_COUNT];
  logic        slot_flag_q   [TIMER_COUNT];
  logic        slot_auto_q   [TIMER_COUNT];
  logic [31:0] slot_reload_q [TIMER_COUNT];
  logic [31:0] slot_rem_q    [TIMER_COUNT];

  // Global state
  logic [15:0] events_q;
  logic [31:0] ms_clock_q;
  logic [7:0]  accum_q;
  logic [31:0] delay_q;

  // Result registers
  logic        done_q;
  logic        acc_q;
  logic        ans_q;
  logic [15:0] did_q;

  // Lowest set bit of a mask, 16 when the mask is zero
  function automatic logic [4:0] lowest_bit(input logic [15:0] m);
    logic [4:0] k;
    k = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) k = 5'(i);
    end
    return k;
  endfunction

  logic [4:0] in_slot;
  logic       in_valid;

  assign in_slot  = lowest_bit(timer_mask_i);
  assign in_valid = (in_slot < 5'(TIMER_COUNT));

  // Hard tick arithmetic
  logic [32:0] clk_sum;
  logic [8:0]  acc_sum;
  logic        soft_fire;

  assign clk_sum   = {1'b0, ms_clock_q} + 33'(HARD_TICK_MS);
  assign acc_sum   = {1'b0, accum_q} + 9'(HARD_TICK_MS);
  assign soft_fire = (acc_sum >= 9'(SOFT_TICK_MS));

  // Shared decrement unit on the addressed slot
  slot_state_t dec_in;
  slot_state_t dec_out;

  assign dec_in.flag      = slot_flag_q[idx_q];
  assign dec_in.auto_rl   = slot_auto_q[idx_q];
  assign dec_in.reload    = slot_reload_q[idx_q];
  assign dec_in.remaining = slot_rem_q[idx_q];

  stb_decr #(
    .SOFT_TICK_MS(SOFT_TICK_MS)
  ) u_decr (
    .slot_i(dec_in),
    .slot_o(dec_out)
  );

  // Sequencer, slot storage and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= CMD_TICK;
      mask_q     <= '0;
      mode_q     <= 1'b0;
      count_q    <= '0;
      valid_q    <= 1'b0;
      idx_q      <= '0;
      events_q   <= '0;
      ms_clock_q <= '0;
      accum_q    <= '0;
      delay_q    <= '0;
      done_q     <= 1'b0;
      acc_q      <= 1'b0;
      ans_q      <= 1'b0;
      did_q      <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        slot_id_q[i]     <= '0;
        slot_in_use_q[i] <= 1'b0;
        slot_flag_q[i]   <= 1'b0;
        slot_auto_q[i]   <= 1'b0;
        slot_reload_q[i] <= '0;
        slot_rem_q[i]    <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            cmd_q   <= command_i;
            mask_q  <= timer_mask_i;
            mode_q  <= auto_reload_i;
            count_q <= count_value_i;
            valid_q <= in_valid;
            idx_q   <= in_slot[IdxW-1:0];
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          acc_q   <= 1'b0;
          ans_q   <= 1'b0;
          did_q   <= '0;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
          case (cmd_q)
            CMD_TICK: begin
              acc_q <= 1'b1;
              if (delay_q != 32'd0) delay_q <= delay_q - 32'd1;
              ms_clock_q <= (clk_sum >= CLOCK_TOP) ? 32'd0 : clk_sum[31:0];
              if (soft_fire) begin
                accum_q <= '0;
                idx_q   <= '0;
                done_q  <= 1'b0;
                state_q <= ST_SCAN;
              end else begin
                accum_q <= acc_sum[7:0];
              end
            end
            CMD_START: begin
              if (valid_q && (count_q < MAX_PERIOD)) begin
                slot_id_q[idx_q]     <= mask_q;
                slot_in_use_q[idx_q] <= 1'b1;
                slot_flag_q[idx_q]   <= 1'b0;
                slot_auto_q[idx_q]   <= mode_q;
                slot_reload_q[idx_q] <= count_q;
                slot_rem_q[idx_q]    <= count_q;
                acc_q                <= 1'b1;
              end
            end
            CMD_STOP: begin
              if (valid_q) begin
                slot_in_use_q[idx_q] <= 1'b0;
                slot_flag_q[idx_q]   <= 1'b0;
                slot_auto_q[idx_q]   <= 1'b0;
                slot_reload_q[idx_q] <= '0;
                slot_rem_q[idx_q]    <= '0;
                events_q             <= events_q & ~mask_q;
                acc_q                <= 1'b1;
              end
            end
            CMD_SET_EVT: begin
              if (valid_q) begin
                slot_id_q[idx_q]     <= mask_q;
                slot_rem_q[idx_q]    <= '0;
                slot_flag_q[idx_q]   <= 1'b1;
                slot_in_use_q[idx_q] <= 1'b1;
                acc_q                <= 1'b1;
              end
            end
            CMD_CLR_EVT: begin
              if (valid_q) begin
                slot_rem_q[idx_q]    <= '0;
                slot_flag_q[idx_q]   <= 1'b0;
                slot_in_use_q[idx_q] <= 1'b0;
                events_q             <= events_q & ~mask_q;
                acc_q                <= 1'b1;
              end
            end
            CMD_POLL: begin
              if (valid_q) begin
                if (slot_flag_q[idx_q]) begin
                  slot_flag_q[idx_q]   <= 1'b0;
                  slot_in_use_q[idx_q] <= 1'b0;
                  ans_q                <= 1'b1;
                end
                acc_q <= 1'b1;
              end
            end
            CMD_QUERY: begin
              if (valid_q) begin
                ans_q <= slot_in_use_q[idx_q];
                acc_q <= 1'b1;
              end
            end
            CMD_DISPATCH: begin
              acc_q   <= 1'b1;
              idx_q   <= '0;
              done_q  <= 1'b0;
              state_q <= ST_SCAN;
            end
            CMD_DELAY: begin
              delay_q <= count_q;
              acc_q   <= 1'b1;
            end
            default: begin
              acc_q <= 1'b0;
            end
          endcase
        end

        ST_SCAN: begin
          if (cmd_q == CMD_DISPATCH) begin
            // Stop at the lowest flagged slot
            if (slot_flag_q[idx_q]) begin
              slot_flag_q[idx_q]   <= 1'b0;
              slot_in_use_q[idx_q] <= 1'b0;
              events_q             <= events_q | slot_id_q[idx_q];
              did_q                <= slot_id_q[idx_q];
              done_q               <= 1'b1;
              state_q              <= ST_IDLE;
            end else if (idx_q == LastIdx) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end else begin
            // Soft tick: one slot through the decrement unit per cycle
            slot_flag_q[idx_q] <= dec_out.flag;
            slot_rem_q[idx_q]  <= dec_out.remaining;
            if (idx_q == LastIdx) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Port drive
  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign accepted_o      = acc_q;
  assign answer_o        = ans_q;
  assign dispatched_id_o = did_q;
  assign event_word_o    = events_q;
  assign clock_ms_o      = ms_clock_q;
  assign delay_busy_o    = (delay_q != 32'd0);

endmodule

`default_nettype wire

// ===== rtl/stb_checker.sv =====
// ---------------------------------------------------------------------------
// stb_checker
// Port-level checks of the timer bank command channel, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        accepted_o,
  input wire logic        answer_o,
  input wire logic [15:0] dispatched_id_o
);

  // An accepted item makes the block busy
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accept without busy")

  // A result closes the item: the block is ready in its cycle
  `ASSERT_IMPL(a_done_ready, clk_i, rst_ni, done_o, !busy_o, "done while busy")

  // A result only follows work
  `ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy_o), "done without work")

  // Rejected commands carry no answer and no identifier
  `ASSERT_IMPL(a_reject_clean, clk_i, rst_ni, done_o && !accepted_o,
               !answer_o && (dispatched_id_o == 16'd0), "reject with payload")

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);

`default_nettype wire

// ===== verif/tb_software_timer_bank.sv =====
// ---------------------------------------------------------------------------
// tb_software_timer_bank
// Self-checking testbench for the software timer bank.
// ---------------------------------------------------------------------------
// Each command item is sent over the start/busy handshake. At the accept
// edge a behavioral timer bank kept inside this bench works out the result
// that the item must produce and queues it. Every done_o strobe is checked,
// field by field, against the oldest queued result. A short directed run
// covers rejects, one-shot, auto-reload and zero-period timers, the delay
// counter, events and dispatch. Random runs with varying sender idle rates
// follow.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_software_timer_bank import stb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMER_COUNT    = 16;
  localparam int unsigned HARD_TICK_MS   = 1;
  localparam int unsigned SOFT_TICK_MS   = 10;
  localparam logic [31:0] MAX_PERIOD     = 32'hFFFF_FFFF;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  // Command codes the block does not implement
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  typedef struct {
    logic        accepted;
    logic        answer;
    logic [15:0] dispatched_id;
    logic [15:0] event_word;
    logic [31:0] clock_ms;
    logic        delay_busy;
  } cmd_result_t;

  // DUT signals
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic [3:0]  command_i     = CMD_TICK;
  logic [15:0] timer_mask_i  = '0;
  logic        auto_reload_i = 1'b0;
  logic [31:0] count_value_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        accepted_o;
  logic        answer_o;
  logic [15:0] dispatched_id_o;
  logic [15:0] event_word_o;
  logic [31:0] clock_ms_o;
  logic        delay_busy_o;

  // Behavioral copy of the timer bank, all zero out of reset
  logic [15:0] tmr_id        [TIMER_COUNT];
  logic        tmr_in_use    [TIMER_COUNT];
  logic        tmr_flag      [TIMER_COUNT];
  logic        tmr_auto      [TIMER_COUNT];
  logic [31:0] tmr_reload    [TIMER_COUNT];
  logic [31:0] tmr_remaining [TIMER_COUNT];
  logic [15:0] event_bits  = '0;
  logic [31:0] ms_count    = '0;
  logic [7:0]  tick_acc    = '0;
  logic [31:0] delay_count = '0;

  cmd_result_t expected_results [$];
  cmd_result_t oldest_result;
  int unsigned sender_idle_pct = 0;
  int unsigned idle_cycles     = 0;
  int unsigned fail_count      = 0;

  software_timer_bank #(
    .TIMER_COUNT  (TIMER_COUNT),
    .HARD_TICK_MS (HARD_TICK_MS),
    .SOFT_TICK_MS (SOFT_TICK_MS),
    .MAX_PERIOD   (MAX_PERIOD)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .timer_mask_i    (timer_mask_i),
    .auto_reload_i   (auto_reload_i),
    .count_value_i   (count_value_i),
    .done_o          (done_o),
    .accepted_o      (accepted_o),
    .answer_o        (answer_o),
    .dispatched_id_o (dispatched_id_o),
    .event_word_o    (event_word_o),
    .clock_ms_o      (clock_ms_o),
    .delay_busy_o    (delay_busy_o)
  );

  // Clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < TIMER_COUNT; i++) begin
      tmr_id[i]        = '0;
      tmr_in_use[i]    = 1'b0;
      tmr_flag[i]      = 1'b0;
      tmr_auto[i]      = 1'b0;
      tmr_reload[i]    = '0;
      tmr_remaining[i] = '0;
    end
  end

  // Decrement every running timer by one soft tick
  function automatic void run_soft_tick();
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (tmr_remaining[i] != 0) begin
        if (tmr_remaining[i] <= SOFT_TICK_MS) begin
          tmr_remaining[i] = '0;
          tmr_flag[i]      = 1'b1;
          if (tmr_auto[i]) tmr_remaining[i] = tmr_reload[i];
        end else begin
          tmr_remaining[i] = tmr_remaining[i] - SOFT_TICK_MS;
        end
      end
    end
  endfunction

  // Apply one command to the bank copy and return the result it must give
  function automatic cmd_result_t predict_command(input logic [3:0] cmd, input logic [15:0] mask,
                                                  input logic mode, input logic [31:0] count);
    cmd_result_t res;
    int          slot;
    logic        slot_ok;
    logic        found;
    logic [32:0] next_clock;
    logic [8:0]  next_acc;
    slot  = TIMER_COUNT;
    found = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (mask[k]) slot = k;
    end
    slot_ok           = (slot < TIMER_COUNT);
    res.accepted      = 1'b0;
    res.answer        = 1'b0;
    res.dispatched_id = '0;
    case (cmd)
      CMD_TICK: begin
        if (delay_count != 0) delay_count = delay_count - 1;
        next_clock = {1'b0, ms_count} + 33'(HARD_TICK_MS);
        ms_count   = (next_clock >= CLOCK_TOP) ? 32'd0 : next_clock[31:0];
        next_acc   = {1'b0, tick_acc} + 9'(HARD_TICK_MS);
        if (next_acc >= SOFT_TICK_MS) begin
          tick_acc = '0;
          run_soft_tick();
        end else begin
          tick_acc = next_acc[7:0];
        end
        res.accepted = 1'b1;
      end
      CMD_START: begin
        if (slot_ok && count < MAX_PERIOD) begin
          tmr_id[slot]        = mask;
          tmr_in_use[slot]    = 1'b1;
          tmr_flag[slot]      = 1'b0;
          tmr_auto[slot]      = mode;
          tmr_reload[slot]    = count;
          tmr_remaining[slot] = count;
          res.accepted        = 1'b1;
        end
      end
      CMD_STOP: begin
        if (slot_ok) begin
          tmr_in_use[slot]    = 1'b0;
          tmr_flag[slot]      = 1'b0;
          tmr_auto[slot]      = 1'b0;
          tmr_reload[slot]    = '0;
          tmr_remaining[slot] = '0;
          event_bits          = event_bits & ~mask;
          res.accepted        = 1'b1;
        end
      end
      CMD_SET_EVT: begin
        if (slot_ok) begin
          tmr_id[slot]        = mask;
          tmr_remaining[slot] = '0;
          tmr_flag[slot]      = 1'b1;
          tmr_in_use[slot]    = 1'b1;
          res.accepted        = 1'b1;
        end
      end
      CMD_CLR_EVT: begin
        if (slot_ok) begin
          tmr_remaining[slot] = '0;
          tmr_flag[slot]      = 1'b0;
          tmr_in_use[slot]    = 1'b0;
          event_bits          = event_bits & ~mask;
          res.accepted        = 1'b1;
        end
      end
      CMD_POLL: begin
        if (slot_ok) begin
          if (tmr_flag[slot]) begin
            tmr_flag[slot]   = 1'b0;
            tmr_in_use[slot] = 1'b0;
            res.answer       = 1'b1;
          end
          res.accepted = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (slot_ok) begin
          res.answer   = tmr_in_use[slot];
          res.accepted = 1'b1;
        end
      end
      CMD_DISPATCH: begin
        // lowest flagged slot only
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (!found && tmr_flag[i]) begin
            found             = 1'b1;
            tmr_flag[i]       = 1'b0;
            tmr_in_use[i]     = 1'b0;
            event_bits        = event_bits | tmr_id[i];
            res.dispatched_id = tmr_id[i];
          end
        end
        res.accepted = 1'b1;
      end
      CMD_DELAY: begin
        delay_count  = count;
        res.accepted = 1'b1;
      end
      default: ;
    endcase
    res.event_word = event_bits;
    res.clock_ms   = ms_count;
    res.delay_busy = (delay_count != 0);
    return res;
  endfunction

  // Send one command item, queue its expected result at the accept edge
  task automatic issue_command(input logic [3:0] cmd, input logic [15:0] mask,
                               input logic mode, input logic [31:0] count);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    command_i     <= cmd;
    timer_mask_i  <= mask;
    auto_reload_i <= mode;
    count_value_i <= count;
    do @(posedge clk_i); while (busy_o);
    expected_results.push_back(predict_command(cmd, mask, mode, count));
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result strobe with no item outstanding");
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        compare_field("accepted", 32'(oldest_result.accepted), 32'(accepted_o));
        compare_field("answer", 32'(oldest_result.answer), 32'(answer_o));
        compare_field("dispatched_id", 32'(oldest_result.dispatched_id),
                      32'(dispatched_id_o));
        compare_field("event_word", 32'(oldest_result.event_word), 32'(event_word_o));
        compare_field("clock_ms", oldest_result.clock_ms, clock_ms_o);
        compare_field("delay_busy", 32'(oldest_result.delay_busy), 32'(delay_busy_o));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Zero masks, a period at the limit and unimplemented codes
  task automatic test_rejected_commands();
    issue_command(CMD_START, 16'h0000, 1'b1, 32'd20);
    issue_command(CMD_POLL, 16'h0000, 1'b0, 32'd0);
    issue_command(CMD_START, 16'h0001, 1'b0, 32'hFFFF_FFFF);
    issue_command(CMD_UNUSED_LO, 16'h0001, 1'b0, 32'd5);
    issue_command(CMD_UNUSED_HI, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
  endtask

  // One-shot, auto-reload and zero-period timers through one soft tick
  task automatic test_timer_expiry();
    issue_command(CMD_START, 16'h0001, 1'b0, 32'd5);
    issue_command(CMD_START, 16'h8000, 1'b1, 32'd10);
    issue_command(CMD_START, 16'h0004, 1'b0, 32'd0);
    issue_command(CMD_DELAY, 16'h0000, 1'b0, 32'd3);
    repeat (SOFT_TICK_MS) issue_command(CMD_TICK, 16'h0000, 1'b0, 32'd0);
    issue_command(CMD_POLL, 16'h0001, 1'b0, 32'd0);
    issue_command(CMD_DISPATCH, 16'h0000, 1'b0, 32'd0);
    issue_command(CMD_DISPATCH, 16'h0000, 1'b0, 32'd0);
  endtask

  // Forced events, clear and stop on the event word
  task automatic test_event_commands();
    issue_command(CMD_SET_EVT, 16'hFFF0, 1'b1, 32'hFFFF_FFFF);
    issue_command(CMD_DISPATCH, 16'h0000, 1'b0, 32'd0);
    issue_command(CMD_CLR_EVT, 16'h0010, 1'b0, 32'd0);
    issue_command(CMD_STOP, 16'h8000, 1'b0, 32'd0);
  endtask

  // Random commands, weighted toward ticks and short timers
  task automatic test_random_commands(input int unsigned n_items, input int unsigned idle_pct);
    int unsigned pick;
    int unsigned slot;
    logic [3:0]  cmd;
    logic [15:0] mask;
    logic        mode;
    logic [31:0] count;
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, TIMER_COUNT - 1);
      mode = 1'($urandom_range(0, 1));
      count = $urandom;
      if ($urandom_range(0, 99) < 5) begin
        mask = '0;
      end else if ($urandom_range(0, 1) != 0) begin
        mask = 16'h0001 << slot;
      end else begin
        mask = 16'($urandom);
        mask = mask & (16'hFFFF << slot);
        mask[slot] = 1'b1;
      end
      if (pick < 40) begin
        cmd = CMD_TICK;
      end else if (pick < 55) begin
        cmd  = CMD_START;
        pick = $urandom_range(0, 99);
        if (pick < 90) count = $urandom_range(0, 80);
        else if (pick >= 95) count = 32'hFFFF_FFFF;
      end else if (pick < 60) begin
        cmd = CMD_STOP;
      end else if (pick < 64) begin
        cmd = CMD_SET_EVT;
      end else if (pick < 68) begin
        cmd = CMD_CLR_EVT;
      end else if (pick < 78) begin
        cmd = CMD_POLL;
      end else if (pick < 82) begin
        cmd = CMD_QUERY;
      end else if (pick < 92) begin
        cmd = CMD_DISPATCH;
      end else if (pick < 96) begin
        cmd = CMD_DELAY;
        if ($urandom_range(0, 99) < 80) count = $urandom_range(0, 30);
      end else begin
        // noise: any code, any mask
        cmd  = 4'($urandom_range(0, 15));
        mask = 16'($urandom);
      end
      issue_command(cmd, mask, mode, count);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rejected_commands();
    test_timer_expiry();
    test_event_commands();
    test_random_commands(640, 0);
    test_random_commands(640, 67);
    test_random_commands(640, 20);

    @(posedge clk_i);
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TIMER_COUNT + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
